// ----- rtl/core/dabaf_pkg.sv -----
// ============================================================================
// dabaf_pkg
// Shared types and constants of the dual-channel block average filter.
// ============================================================================
`default_nettype none

package dabaf_pkg;

  // parameter defaults
  localparam int BLOCK_LEN_DEF   = 16;
  localparam int HISTORY_LEN_DEF = 4;
  localparam int SAMPLE_BITS_DEF = 12;

  // scaling to degrees: value * 50 / 2081 (division by 41.62)
  localparam int SCALE_NUM   = 50;
  localparam int SCALE_NUM_W = 6;
  localparam int SCALE_DEN   = 2081;
  localparam int SCALE_DEN_W = 12;

  // result and calibration widths
  localparam int OUT_W       = 9;
  localparam int OUT_MAX     = 511;
  localparam int OFS_W       = 8;
  localparam int OUT_TDATA_W = 24;

  // output buffer depth, power of two
  localparam int OUT_DEPTH   = 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH0   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBTRACT_CH0 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH1   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUBTRACT_CH1 = 4'd3;

  // per-beat control handed to each lane
  typedef struct packed {
    logic acc;   // a beat is taken this cycle
    logic last;  // that beat closes a block
  } lane_ctl_t;

  // calibration settings of one lane
  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic             subtract;
  } lane_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/dabaf_lane.sv -----
// ============================================================================
// dabaf_lane
// One channel: block accumulator, exact constant-division pipeline,
// history ring, ring mean and offset correction.
// ============================================================================
`default_nettype none

module dabaf_lane
  import dabaf_pkg::*;
#(
  parameter int BLOCK_LEN   = BLOCK_LEN_DEF,
  parameter int HISTORY_LEN = HISTORY_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lane_ctl_t              ctl,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire lane_cfg_t              cfg,
  output logic                        res_valid,
  output logic [OUT_W-1:0]            res_temp
);

  // block sum and division by the block length
  localparam int SUM_W = SAMPLE_BITS + $clog2(BLOCK_LEN);
  localparam int K1    = SUM_W + $clog2(BLOCK_LEN);
  localparam int P1_W  = K1 + SAMPLE_BITS;
  localparam logic [63:0] M1 = (64'd1 << K1) / 64'(BLOCK_LEN) + 64'd1;

  // average times fifty and division by the scale denominator
  localparam int AV_W   = SAMPLE_BITS + SCALE_NUM_W;
  localparam int SC_MAX = ((2 ** SAMPLE_BITS - 1) * SCALE_NUM) / SCALE_DEN;
  localparam int SC_W   = $clog2(SC_MAX + 1);
  localparam int K2     = AV_W + SCALE_DEN_W;
  localparam int P2_W   = K2 + SC_W;
  localparam logic [63:0] M2 = (64'd1 << K2) / 64'(SCALE_DEN) + 64'd1;

  // ring total and division by the ring length
  localparam int TOT_W = SC_W + $clog2(HISTORY_LEN);
  localparam int K3    = TOT_W + $clog2(HISTORY_LEN);
  localparam int P3_W  = K3 + SC_W;
  localparam logic [63:0] M3 = (64'd1 << K3) / 64'(HISTORY_LEN) + 64'd1;

  localparam int SLOT_W = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
  localparam int MAX_AB = (SC_W > OFS_W) ? SC_W : OFS_W;
  localparam int RES_W  = ((MAX_AB > OUT_W) ? MAX_AB : OUT_W) + 1;

  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  blk_r;
  logic [P1_W-1:0]   p1_r;
  logic [AV_W-1:0]   av50_r;
  logic [P2_W-1:0]   p2_r;
  logic [SC_W-1:0]   hist_r [HISTORY_LEN];
  logic [SLOT_W-1:0] slot_r;
  logic [TOT_W-1:0]  tot_r;
  logic [TOT_W-1:0]  tot_nxt;
  logic [P3_W-1:0]   p3_r;
  logic [OUT_W-1:0]  res_r;
  logic [OUT_W-1:0]  res_nxt;
  logic [8:1]        vld_r;
  logic [SUM_W-1:0]  sum_add;
  logic [SAMPLE_BITS-1:0] avg;
  logic [SC_W-1:0]   scaled;
  logic [SC_W-1:0]   mean;

  assign sum_add = sum_r + SUM_W'(sample);
  assign avg     = p1_r[K1 +: SAMPLE_BITS];
  assign scaled  = p2_r[K2 +: SC_W];
  assign mean    = p3_r[K3 +: SC_W];

  // stage valid chain, one bit per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[7:1], ctl.acc & ctl.last};
    end
  end

  // running sum, restarts after the closing beat of a block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.acc) begin
      sum_r <= ctl.last ? '0 : sum_add;
    end
  end

  // closing sum of the block
  always_ff @(posedge clk) begin
    if (ctl.acc && ctl.last) begin
      blk_r <= sum_add;
    end
  end

  // arithmetic pipeline, exact reciprocal multiplies
  always_ff @(posedge clk) begin
    p1_r   <= P1_W'(blk_r) * P1_W'(M1);
    av50_r <= AV_W'(avg) * AV_W'(SCALE_NUM);
    p2_r   <= P2_W'(av50_r) * P2_W'(M2);
    tot_r  <= tot_nxt;
    p3_r   <= P3_W'(tot_r) * P3_W'(M3);
    res_r  <= res_nxt;
  end

  // history ring, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_LEN; i++) begin
        hist_r[i] <= '0;
      end
      slot_r <= '0;
    end else if (vld_r[4]) begin
      hist_r[slot_r] <= scaled;
      slot_r <= (slot_r == SLOT_W'(HISTORY_LEN - 1)) ? '0 : slot_r + SLOT_W'(1);
    end
  end

  // ring total
  always_comb begin
    tot_nxt = '0;
    for (int i = 0; i < HISTORY_LEN; i++) begin
      tot_nxt = tot_nxt + TOT_W'(hist_r[i]);
    end
  end

  // offset correction, clamp at zero and saturate at the top
  always_comb begin
    logic [RES_W-1:0] mean_w;
    logic [RES_W-1:0] ofs_w;
    logic [RES_W-1:0] r;
    mean_w = RES_W'(mean);
    ofs_w  = RES_W'(cfg.offset);
    if (cfg.subtract) begin
      r = (mean_w >= ofs_w) ? mean_w - ofs_w : '0;
    end else begin
      r = mean_w + ofs_w;
    end
    if (r > RES_W'(OUT_MAX)) begin
      r = RES_W'(OUT_MAX);
    end
    res_nxt = r[OUT_W-1:0];
  end

  assign res_valid = vld_r[8];
  assign res_temp  = res_r;

endmodule

`default_nettype wire

// ----- rtl/core/dabaf_ofifo.sv -----
// ============================================================================
// dabaf_ofifo
// Merging stage: joins the two lane results into one beat and buffers it
// towards the result channel.
// ============================================================================
`default_nettype none

module dabaf_ofifo
  import dabaf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push0,
  input  wire logic                   push1,
  input  wire logic [OUT_W-1:0]       temp0,
  input  wire logic [OUT_W-1:0]       temp1,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  logic [2*OUT_W-1:0] buf_r [OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               push;
  logic               pop;

  // both lanes finish a block in the same cycle
  assign push = push0 & push1;
  assign pop  = out_tvalid & out_tready;

  // entry store
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= {temp1, temp0};
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {(OUT_TDATA_W - 2*OUT_W)'(0), buf_r[rd_ptr_r]};

endmodule

`default_nettype wire

// ----- rtl/core/dual_adc_block_average_filter_core.sv -----
// ============================================================================
// dual_adc_block_average_filter_core
// Two-channel block average, scaling to degrees, history mean and offset.
// ============================================================================
//
//  channel  direction  beat contents (low bits first)
//  in_      slave      tdata: sample_ch0, sample_ch1, zero fill to bytes
//  out_     master     tdata: temp_ch0[8:0], temp_ch1[17:9], zero fill
//  cfg_     write      index 0..3: offset_ch0, subtract_ch0, offset_ch1,
//                      subtract_ch1
//
//  one input beat per cycle, but for the hold-off below; a result leaves through
//  the 8 lane stages and the output buffer after the beat that closes a block
//  synchronous reset clears sums, counters, history and settings at once
//  the output buffer holds 8 results; input is held off only for a beat
//  that closes a block while 8 results are still pending
// ============================================================================
`default_nettype none

module dual_adc_block_average_filter_core
  import dabaf_pkg::*;
#(
  parameter int BLOCK_LEN   = BLOCK_LEN_DEF,
  parameter int HISTORY_LEN = HISTORY_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_W-1:0]        in_tdata,   // sample_ch0, sample_ch1
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // temp_ch0, temp_ch1
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [OFS_W-1:0]       cfg_wdata
);

  localparam int CNT_W  = $clog2(BLOCK_LEN);
  localparam int PEND_W = $clog2(OUT_DEPTH + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic [PEND_W-1:0] pend_r;
  lane_cfg_t         cfg0_r;
  lane_cfg_t         cfg1_r;
  lane_ctl_t         ctl;
  logic              last;
  logic              in_acc;
  logic              out_acc;
  logic              v0;
  logic              v1;
  logic [OUT_W-1:0]  t0;
  logic [OUT_W-1:0]  t1;

  assign last      = (cnt_r == CNT_W'(BLOCK_LEN - 1));
  assign in_tready = !(last && (pend_r == PEND_W'(OUT_DEPTH)));
  assign in_acc    = in_tvalid & in_tready;
  assign out_acc   = out_tvalid & out_tready;
  assign ctl.acc   = in_acc;
  assign ctl.last  = last;

  // position within the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= last ? '0 : cnt_r + CNT_W'(1);
    end
  end

  // results in flight or buffered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + PEND_W'(in_acc & last) - PEND_W'(out_acc);
    end
  end

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg0_r <= '0;
      cfg1_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_CH0:   cfg0_r.offset   <= cfg_wdata;
        REG_SUBTRACT_CH0: cfg0_r.subtract <= cfg_wdata[0];
        REG_OFFSET_CH1:   cfg1_r.offset   <= cfg_wdata;
        REG_SUBTRACT_CH1: cfg1_r.subtract <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // channel lanes
  dabaf_lane #(
    .BLOCK_LEN   (BLOCK_LEN),
    .HISTORY_LEN (HISTORY_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sample    (in_tdata[SAMPLE_BITS-1:0]),
    .cfg       (cfg0_r),
    .res_valid (v0),
    .res_temp  (t0)
  );

  dabaf_lane #(
    .BLOCK_LEN   (BLOCK_LEN),
    .HISTORY_LEN (HISTORY_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sample    (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .cfg       (cfg1_r),
    .res_valid (v1),
    .res_temp  (t1)
  );

  // merge and output buffer
  dabaf_ofifo u_ofifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push0      (v0),
    .push1      (v1),
    .temp0      (t0),
    .temp1      (t1),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
